### sv/ifsc_pkg.sv
// ----------------------------------------------------------------------------
// ifsc_pkg
// Widths shared by the frame sync and checksum core and its channel
// interfaces, and the reset value of the core's sync word.
// ----------------------------------------------------------------------------
package ifsc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned TOTAL_W = 32;

	localparam logic [WORD_W-1:0] SYNC_RESET = 16'h55AA;

	typedef logic [BYTE_W-1:0]         byte_t;
	typedef logic signed [WORD_W-1:0]  word_t;
	typedef logic [INDEX_W-1:0]        index_t;
	typedef logic [TOTAL_W-1:0]        total_t;

endpackage

### sv/ifsc_byte_if.sv
// ----------------------------------------------------------------------------
// ifsc_byte_if
// Valid/ready channel that carries one received byte per transaction.
// ----------------------------------------------------------------------------
interface ifsc_byte_if;
	import ifsc_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);

endinterface

### sv/ifsc_word_if.sv
// ----------------------------------------------------------------------------
// ifsc_word_if
// Valid/ready channel that carries one decoded frame word per transaction,
// with its index, frame end flag, checksum status and message total.
// ----------------------------------------------------------------------------
interface ifsc_word_if;
	import ifsc_pkg::*;

	logic   valid;
	logic   ready;
	word_t  word_value;
	index_t word_index;
	logic   frame_end;
	logic   checksum_ok;
	total_t message_total;

	modport source (output valid, output word_value, output word_index,
		output frame_end, output checksum_ok, output message_total, input ready);
	modport sink   (input valid, input word_value, input word_index,
		input frame_end, input checksum_ok, input message_total, output ready);

endinterface

### sv/imu_frame_sync_checksum_core.sv
// ----------------------------------------------------------------------------
// imu_frame_sync_checksum_core
// Sync word framer for a sensor byte stream with a 16-bit checksum check.
// ----------------------------------------------------------------------------
// The core takes one byte per transaction on rx and, when rx is not stalled,
// accepts one byte per clock: each byte is handled in the cycle it is
// accepted and any word it completes lands in the result register in the
// following cycle, from which res takes it. rx stalls only while the result
// register holds a word that res has not taken. The core hunts for the sync
// word (high byte first; a wrong low byte is consumed and hunting restarts),
// then emits every big-endian word of a FRAME_BYTES frame with its index,
// word 0 being the sync word. The final word is the checksum: the frame is
// good when it equals the negated 16-bit sum of all earlier words. On a good
// frame message_total grows by the absolute difference of the magnitudes of
// word 1 and word 1 of the previous good frame. sync_word is written through
// cfg_we/cfg_wdata and should only change while the core is idle.
// ----------------------------------------------------------------------------
module imu_frame_sync_checksum_core #(
	parameter int unsigned FRAME_BYTES = 68
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ifsc_byte_if.sink              rx,
	ifsc_word_if.source            res,
	input  logic                   cfg_we,
	input  logic [ifsc_pkg::WORD_W-1:0] cfg_wdata
);
	import ifsc_pkg::*;

	localparam int unsigned WORD_COUNT = FRAME_BYTES / 2;
	localparam int unsigned IDX_W      = $clog2(WORD_COUNT);
	localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(WORD_COUNT - 1);
	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(WORD_COUNT - 1);

	typedef enum logic [1:0] {
		HUNT_HI,
		HUNT_LO,
		COLLECT
	} state_t;

	state_t                 state_q;
	logic [WORD_W-1:0]      sync_q;
	logic                   lo_q;
	logic [IDX_W-1:0]       idx_q;
	logic [BYTE_W-1:0]      hi_q;
	logic [WORD_W-1:0]      sum_q;
	logic [WORD_W-1:0]      cnt_word_q;
	logic [WORD_W-1:0]      prev_word_q;
	total_t                 total_q;

	logic                   out_valid_q;
	word_t                  out_word_q;
	index_t                 out_index_q;
	logic                   out_end_q;
	logic                   out_ok_q;
	total_t                 out_total_q;

	logic                   accept;
	logic                   emit;
	logic [WORD_W-1:0]      word_cat;
	logic [WORD_W:0]        mag_cur;
	logic [WORD_W:0]        mag_prev;
	logic [WORD_W:0]        mag_diff;
	logic                   chk_ok;
	total_t                 total_good;
	logic [IDX_W+INDEX_W-1:0] idx_ext;

	assign rx.ready = !out_valid_q || res.ready;
	assign accept   = rx.valid && rx.ready;

	always_comb begin
		word_cat   = {hi_q, rx.rx_byte};
		// a transaction that completes a word or the sync word fills the result register
		emit       = accept && ((state_q == HUNT_LO && rx.rx_byte == sync_q[BYTE_W-1:0])
			|| (state_q == COLLECT && lo_q));
		mag_cur    = cnt_word_q[WORD_W-1] ? ((WORD_W+1)'(1) << WORD_W) - {1'b0, cnt_word_q}
			: {1'b0, cnt_word_q};
		mag_prev   = prev_word_q[WORD_W-1] ? ((WORD_W+1)'(1) << WORD_W) - {1'b0, prev_word_q}
			: {1'b0, prev_word_q};
		mag_diff   = (mag_cur >= mag_prev) ? mag_cur - mag_prev : mag_prev - mag_cur;
		chk_ok     = (WORD_W'(-sum_q) == word_cat);
		total_good = total_q + TOTAL_W'(mag_diff);
		idx_ext    = {{INDEX_W{1'b0}}, idx_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= HUNT_HI;
			sync_q      <= SYNC_RESET;
			lo_q        <= 1'b0;
			idx_q       <= '0;
			hi_q        <= '0;
			sum_q       <= '0;
			cnt_word_q  <= '0;
			prev_word_q <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_index_q <= '0;
			out_end_q   <= 1'b0;
			out_ok_q    <= 1'b0;
			out_total_q <= '0;
		end else begin
			if (cfg_we) begin
				sync_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				case (state_q)
					HUNT_HI: begin
						if (rx.rx_byte == sync_q[WORD_W-1:BYTE_W]) begin
							state_q <= HUNT_LO;
						end
					end
					HUNT_LO: begin
						if (rx.rx_byte != sync_q[BYTE_W-1:0]) begin
							state_q <= HUNT_HI;
						end else begin
							state_q     <= COLLECT;
							lo_q        <= 1'b0;
							idx_q       <= IDX_W'(1);
							sum_q       <= sync_q;
							cnt_word_q  <= '0;
							out_word_q  <= sync_q;
							out_index_q <= '0;
							out_end_q   <= 1'b0;
							out_ok_q    <= 1'b0;
							out_total_q <= total_q;
						end
					end
					COLLECT: begin
						if (!lo_q) begin
							// hold the high byte until its partner arrives
							hi_q <= rx.rx_byte;
							lo_q <= 1'b1;
						end else begin
							lo_q        <= 1'b0;
							out_word_q  <= word_cat;
							out_index_q <= idx_ext[INDEX_W-1:0];
							if (idx_q != LAST_WORD) begin
								sum_q       <= sum_q + word_cat;
								idx_q       <= idx_q + IDX_W'(1);
								out_end_q   <= 1'b0;
								out_ok_q    <= 1'b0;
								out_total_q <= total_q;
								if (idx_q == IDX_W'(1)) begin
									cnt_word_q <= word_cat;
								end
							end else begin
								// checksum word: settle the frame and go back to hunting
								state_q   <= HUNT_HI;
								out_end_q <= 1'b1;
								out_ok_q  <= chk_ok;
								if (chk_ok) begin
									total_q     <= total_good;
									prev_word_q <= cnt_word_q;
									out_total_q <= total_good;
								end else begin
									out_total_q <= total_q;
								end
							end
						end
					end
					default: begin
						state_q <= HUNT_HI;
					end
				endcase
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.word_value    = out_word_q;
	assign res.word_index    = out_index_q;
	assign res.frame_end     = out_end_q;
	assign res.checksum_ok   = out_ok_q;
	assign res.message_total = out_total_q;

`ifndef SYNTH
	a_ok_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.checksum_ok |-> res.frame_end)
		else $error("checksum_ok raised on a word that does not end the frame");

	a_end_index: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_end |-> res.word_index == LAST_INDEX)
		else $error("frame end reported on a word other than the last");

	a_end_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q == COLLECT && lo_q && idx_q == LAST_WORD |=> state_q == HUNT_HI)
		else $error("hunting did not restart after the checksum word");

	a_total_on_good: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != $past(total_q) |-> $past(accept && state_q == COLLECT && lo_q
			&& idx_q == LAST_WORD && chk_ok))
		else $error("message total moved without a good frame");

	a_sync_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q == HUNT_LO && rx.rx_byte == sync_q[BYTE_W-1:0]
		|=> out_valid_q && out_index_q == '0 && !out_end_q)
		else $error("sync word not presented as word zero");
`endif

endmodule
